### src/hrf_pkg.sv
// Shared types and constants for the HTTP request framer.
// Request and result payloads, parser phase codes and the header key text.
// No dependencies.
`default_nettype none

package hrf_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       peer_closed;
    } hrf_req_t;

    typedef struct packed {
        logic [31:0] header_length;
        logic [31:0] body_length;
    } hrf_res_t;

    typedef struct packed {
        logic        nl_pair;
        logic [31:0] length;
    } hrf_parse_t;

    typedef struct packed {
        logic step;
        logic clr;
    } hrf_ctrl_t;

    localparam logic [2:0] PH_MATCH      = 3'd0;
    localparam logic [2:0] PH_SKIP_LINE  = 3'd1;
    localparam logic [2:0] PH_SEEK_COLON = 3'd2;
    localparam logic [2:0] PH_SKIP_WS    = 3'd3;
    localparam logic [2:0] PH_AFTER_SIGN = 3'd4;
    localparam logic [2:0] PH_DIGITS     = 3'd5;
    localparam logic [2:0] PH_DONE       = 3'd6;

    localparam logic [3:0] KEY_LEN = 4'd14;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### src/http_request_framer_top.sv
//  channel | ports                    | payload      | role
//  --------+--------------------------+--------------+------------------------------
//  s_      | s_valid s_ready s_req    | hrf_req_t    | request bytes and peer close
//  m_      | m_valid m_ready m_res    | hrf_res_t    | header and body lengths
//
// One request per cycle sustained while no waiting result stalls it; the request that
// completes a result passes the input register, then the result goes to the result register.
// The per-byte state update is one pass of logic between the two registers.
// A waiting result stalls only a request that would produce another result.
// aresetn is synchronous, active low, and clears all framing state.
`default_nettype none

module http_request_framer_top (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire hrf_pkg::hrf_req_t s_req,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output hrf_pkg::hrf_res_t      m_res
);
    import hrf_pkg::*;

    logic       in_valid_reg;
    hrf_req_t   in_req_reg;
    logic       out_valid_reg;
    hrf_res_t   out_res_reg;

    logic       advance;
    logic       emit;
    hrf_res_t   res;
    hrf_ctrl_t  ctrl;
    hrf_parse_t status;

    hrf_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .data_byte (in_req_reg.data_byte),
        .status    (status)
    );

    hrf_framer u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item       (in_req_reg),
        .advance    (advance),
        .status     (status),
        .emit       (emit),
        .res        (res),
        .ctrl       (ctrl)
    );

    always_comb begin
        advance = in_valid_reg && (!emit || !out_valid_reg || m_ready);
        s_ready = !in_valid_reg || advance;
        m_valid = out_valid_reg;
        m_res   = out_res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= s_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_res_reg <= res;
        end
    end

endmodule

`default_nettype wire

### src/hrf_parser.sv
// Header parser: key match for the length line, colon search and signed number read,
// plus detection of the blank line that ends the header.
// Depends on hrf_pkg.
`default_nettype none

module hrf_parser (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire hrf_pkg::hrf_ctrl_t ctrl,
    input  wire logic [7:0]         data_byte,
    output hrf_pkg::hrf_parse_t     status
);
    import hrf_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  match_reg, match_next;
    logic        neg_reg, neg_next;
    logic [31:0] acc_reg, acc_next;
    logic        found_reg, found_next;
    logic        prev_nl_reg, prev_nl_next;

    logic [7:0]  lc;
    logic        is_digit;
    logic        is_ws;
    logic [35:0] acc_sum;
    logic [31:0] acc_dig;
    logic [3:0]  match_inc;

    always_comb begin
        lc = ((data_byte >= CH_UPPER_A) && (data_byte <= CH_UPPER_Z)) ?
             data_byte + CASE_OFFSET : data_byte;
        is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
        is_ws = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
        acc_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                  + {32'd0, 4'(data_byte - CH_ZERO)};
        acc_dig = (acc_sum > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : acc_sum[31:0];
        match_inc = match_reg + 4'd1;
    end

    always_comb begin
        phase_next = phase_reg;
        match_next = match_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        found_next = found_reg;
        unique case (phase_reg)
            PH_MATCH: begin
                if ((match_reg < KEY_LEN) && (lc == key_char(match_reg))) begin
                    match_next = match_inc;
                    if (match_inc >= KEY_LEN) begin
                        phase_next = PH_SEEK_COLON;
                    end
                end else if (data_byte == CH_LF) begin
                    match_next = 4'd0;
                end else begin
                    phase_next = PH_SKIP_LINE;
                end
            end
            PH_SKIP_LINE: begin
                if (data_byte == CH_LF) begin
                    phase_next = PH_MATCH;
                    match_next = 4'd0;
                end
            end
            PH_SEEK_COLON: begin
                if (data_byte == CH_COLON) begin
                    phase_next = PH_SKIP_WS;
                    found_next = 1'b1;
                end
            end
            PH_SKIP_WS: begin
                if (!is_ws) begin
                    if (data_byte == CH_PLUS) begin
                        phase_next = PH_AFTER_SIGN;
                    end else if (data_byte == CH_MINUS) begin
                        neg_next   = 1'b1;
                        phase_next = PH_AFTER_SIGN;
                    end else if (is_digit) begin
                        acc_next   = acc_dig;
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_AFTER_SIGN, PH_DIGITS: begin
                if (is_digit) begin
                    acc_next   = acc_dig;
                    phase_next = PH_DIGITS;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        if (data_byte == CH_LF) begin
            prev_nl_next = 1'b1;
        end else if (data_byte != CH_CR) begin
            prev_nl_next = 1'b0;
        end else begin
            prev_nl_next = prev_nl_reg;
        end
    end

    always_comb begin
        status.nl_pair = (data_byte == CH_LF) && prev_nl_reg;
        if (!found_reg) begin
            status.length = 32'd0;
        end else if (neg_reg) begin
            status.length = 32'd0 - acc_reg;
        end else begin
            status.length = (acc_reg > POS_LIMIT) ? POS_LIMIT : acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clr) begin
            phase_reg   <= PH_MATCH;
            match_reg   <= 4'd0;
            neg_reg     <= 1'b0;
            acc_reg     <= 32'd0;
            found_reg   <= 1'b0;
            prev_nl_reg <= 1'b0;
        end else if (ctrl.step) begin
            phase_reg   <= phase_next;
            match_reg   <= match_next;
            neg_reg     <= neg_next;
            acc_reg     <= acc_next;
            found_reg   <= found_next;
            prev_nl_reg <= prev_nl_next;
        end
    end

endmodule

`default_nettype wire

### src/hrf_framer.sv
// Request framing: byte count, header size, body size and the completion test.
// Drives the parser's step and clear; decides when a result is due.
// Depends on hrf_pkg.
`default_nettype none

module hrf_framer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                item_valid,
    input  wire hrf_pkg::hrf_req_t   item,
    input  wire logic                advance,
    input  wire hrf_pkg::hrf_parse_t status,
    output logic                     emit,
    output hrf_pkg::hrf_res_t        res,
    output hrf_pkg::hrf_ctrl_t       ctrl
);
    import hrf_pkg::*;

    logic [31:0] bc_reg;
    logic [31:0] hs_reg;
    logic [31:0] cs_reg;
    logic        rc_reg;

    logic [31:0] bc_next;
    logic        rc_next;
    logic        is_byte;
    logic        hdr_open;
    logic        hdr_now;
    logic        close_fill;
    logic [32:0] sum;
    logic        emit_raw;

    always_comb begin
        is_byte    = !item.peer_closed;
        bc_next    = (is_byte && !(&bc_reg)) ? bc_reg + 32'd1 : bc_reg;
        rc_next    = rc_reg | item.peer_closed;
        hdr_open   = (hs_reg == 32'd0);
        hdr_now    = is_byte && hdr_open && status.nl_pair;
        close_fill = rc_next && (cs_reg == 32'd0);
        sum        = {1'b0, hs_reg} + {1'b0, cs_reg};

        if (hdr_now) begin
            emit_raw          = (status.length == 32'd0);
            res.header_length = bc_next;
            res.body_length   = 32'd0;
        end else if (!hdr_open) begin
            emit_raw = close_fill ||
                       ((cs_reg < bc_next) &&
                        ((cs_reg == 32'd0) || (sum <= {1'b0, bc_next})));
            res.header_length = hs_reg;
            res.body_length   = close_fill ? bc_next - hs_reg : cs_reg;
        end else begin
            emit_raw          = 1'b0;
            res.header_length = hs_reg;
            res.body_length   = cs_reg;
        end

        emit      = item_valid && emit_raw;
        ctrl.step = advance && is_byte && hdr_open;
        ctrl.clr  = advance && emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg <= 32'd0;
            hs_reg <= 32'd0;
            cs_reg <= 32'd0;
            rc_reg <= 1'b0;
        end else if (advance) begin
            rc_reg <= rc_next;
            if (emit) begin
                bc_reg <= 32'd0;
                hs_reg <= 32'd0;
                cs_reg <= 32'd0;
            end else begin
                bc_reg <= bc_next;
                if (hdr_now) begin
                    hs_reg <= bc_next;
                    cs_reg <= status.length;
                end
            end
        end
    end

    a_close_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        rc_reg |=> rc_reg)
        else $error("peer close flag dropped without reset");

    a_clear_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> (bc_reg == 32'd0) && (hs_reg == 32'd0))
        else $error("framing state not cleared after a result");

    a_header_in_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (hs_reg != 32'd0) |-> (hs_reg <= bc_reg))
        else $error("header size exceeds byte count");

    a_emit_header: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (res.header_length != 32'd0))
        else $error("result with empty header");

endmodule

`default_nettype wire
